### hdl/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

	// Field widths
	localparam int COUNT_W    = 16;
	localparam int PRESCALE_W = 10;
	localparam int MODE_W     = 2;
	localparam int CLKSEL_W   = 3;
	localparam int ENABLE_W   = 3;
	localparam int REG_IDX_W  = 3;

	// Operation codes of an input request
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Timer modes; the unused code behaves as free-running wrap
	localparam logic [MODE_W-1:0] MODE_WRAP      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR_A   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR_TOP = 2'd2;

	// Clock select codes; the unused codes behave as stopped
	localparam logic [CLKSEL_W-1:0] CS_STOPPED = 3'd0;
	localparam logic [CLKSEL_W-1:0] CS_DIV1    = 3'd1;
	localparam logic [CLKSEL_W-1:0] CS_DIV8    = 3'd2;
	localparam logic [CLKSEL_W-1:0] CS_DIV64   = 3'd3;
	localparam logic [CLKSEL_W-1:0] CS_DIV256  = 3'd4;
	localparam logic [CLKSEL_W-1:0] CS_DIV1024 = 3'd5;

	// Register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_TIMER_MODE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLOCK_SELECT    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COMPARE_A       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COMPARE_B       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TOP_VALUE       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CAPTURE_RISING  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_NOISE_FILTER_ON = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_EVENT_ENABLES   = 3'd7;

	// Bit positions within the event enable register
	localparam int EN_COMPARE_A = 0;
	localparam int EN_COMPARE_B = 1;
	localparam int EN_CAPTURE   = 2;

endpackage

`default_nettype wire

### hdl/tcc_cfg_if.sv
`default_nettype none

interface tcc_cfg_if;
	import tcc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [COUNT_W-1:0]   wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### hdl/tcc_tick_if.sv
`default_nettype none

interface tcc_tick_if;
	import tcc_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic               capture_pin;
	logic [COUNT_W-1:0] write_value;

	modport source (output valid, output operation, output capture_pin, output write_value,
		input ready);
	modport sink (input valid, input operation, input capture_pin, input write_value,
		output ready);
endinterface

`default_nettype wire

### hdl/tcc_result_if.sv
`default_nettype none

interface tcc_result_if;
	import tcc_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] count_now;
	logic [COUNT_W-1:0] captured_count;
	logic               compare_a_event;
	logic               compare_b_event;
	logic               capture_event;

	modport source (output valid, output count_now, output captured_count,
		output compare_a_event, output compare_b_event, output capture_event, input ready);
	modport sink (input valid, input count_now, input captured_count,
		input compare_a_event, input compare_b_event, input capture_event, output ready);
endinterface

`default_nettype wire

### hdl/timer_counter_16bit_capture_compare.sv
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register is refilled in the
// same cycle that its contents are taken, so the input stalls only while a result waits.
// Reset (arst_n low, asynchronous): configuration, counter, prescaler, capture latch,
// pin history and filtered level all clear to zero and no result is pending.
`default_nettype none

module timer_counter_16bit_capture_compare #(
	parameter int FILTER_SAMPLES = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tcc_cfg_if.sink        cfg,
	tcc_tick_if.sink       tick,
	tcc_result_if.source   result
);
	import tcc_pkg::*;

	// Configuration registers
	logic [MODE_W-1:0]   timer_mode_q;
	logic [CLKSEL_W-1:0] clock_select_q;
	logic [COUNT_W-1:0]  compare_a_q;
	logic [COUNT_W-1:0]  compare_b_q;
	logic [COUNT_W-1:0]  top_value_q;
	logic                capture_rising_q;
	logic                noise_filter_on_q;
	logic [ENABLE_W-1:0] event_enables_q;

	// Timer state
	logic [PRESCALE_W-1:0]     prescale_q;
	logic [COUNT_W-1:0]        timer_q;
	logic [COUNT_W-1:0]        capture_q;
	logic [FILTER_SAMPLES-1:0] pin_history_q;
	logic                      filtered_q;

	// Result register
	logic               res_valid_q;
	logic [COUNT_W-1:0] res_count_q;
	logic [COUNT_W-1:0] res_capture_q;
	logic               res_ev_a_q;
	logic               res_ev_b_q;
	logic               res_ev_cap_q;

	// Next-state logic
	logic                      accept;
	logic                      is_tick;
	logic [PRESCALE_W-1:0]     prescale_next;
	logic                      timer_clock;
	logic [FILTER_SAMPLES-1:0] history_next;
	logic                      level_next;
	logic                      capture_hit;
	logic                      match_a;
	logic                      match_b;
	logic                      match_top;
	logic [COUNT_W-1:0]        timer_next;
	logic [COUNT_W-1:0]        capture_next;

	// Never stalls; the user must write only while the block is idle (unenforced).
	assign cfg.ready = 1'b1;

	// A new request is taken whenever the result register is empty or is being emptied
	// in this very cycle, so back-to-back requests flow without a bubble.
	assign tick.ready = !res_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;
	assign is_tick    = (tick.operation == OP_TICK);

	// The prescaler runs freely on every tick. Its divided outputs fire when the
	// relevant low bits of the incremented value wrap round to zero.
	assign prescale_next = prescale_q + PRESCALE_W'(1);

	always_comb begin
		case (clock_select_q)
			CS_DIV1:    timer_clock = 1'b1;
			CS_DIV8:    timer_clock = (prescale_next[2:0] == '0);
			CS_DIV64:   timer_clock = (prescale_next[5:0] == '0);
			CS_DIV256:  timer_clock = (prescale_next[7:0] == '0);
			CS_DIV1024: timer_clock = (prescale_next == '0);
			default:    timer_clock = 1'b0;
		endcase
	end

	// Edge detection. The newest pin sample enters at bit 0 of the history. With the
	// filter enabled the level only moves once every stored sample agrees with it;
	// without the filter the level simply follows the pin.
	if (FILTER_SAMPLES > 1) begin : g_hist
		assign history_next = {pin_history_q[FILTER_SAMPLES-2:0], tick.capture_pin};
	end else begin : g_hist_one
		assign history_next = tick.capture_pin;
	end

	always_comb begin
		level_next = filtered_q;
		if (!noise_filter_on_q) begin
			level_next = tick.capture_pin;
		end else if (&history_next) begin
			level_next = 1'b1;
		end else if (~|history_next) begin
			level_next = 1'b0;
		end
	end

	// Capture takes the count held at the start of the tick. It is suppressed in
	// top-register mode, although the edge detector keeps following the pin there.
	assign capture_hit = (level_next != filtered_q) && (level_next == capture_rising_q)
		&& (timer_mode_q != MODE_CLEAR_TOP);
	assign capture_next = capture_hit ? timer_q : capture_q;

	// Compare matches are judged against the count held before this timer clock.
	assign match_a   = (timer_q == compare_a_q);
	assign match_b   = (timer_q == compare_b_q);
	assign match_top = (timer_q == top_value_q);

	// In the clear-on-match modes a count already above the clear value runs on to the
	// natural wrap before it can meet that value again.
	always_comb begin
		timer_next = timer_q;
		if (timer_clock) begin
			if ((timer_mode_q == MODE_CLEAR_A) && match_a) begin
				timer_next = '0;
			end else if ((timer_mode_q == MODE_CLEAR_TOP) && match_top) begin
				timer_next = '0;
			end else begin
				timer_next = timer_q + COUNT_W'(1);
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_mode_q      <= '0;
			clock_select_q    <= '0;
			compare_a_q       <= '0;
			compare_b_q       <= '0;
			top_value_q       <= '0;
			capture_rising_q  <= 1'b0;
			noise_filter_on_q <= 1'b0;
			event_enables_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TIMER_MODE:      timer_mode_q      <= cfg.wdata[MODE_W-1:0];
				REG_CLOCK_SELECT:    clock_select_q    <= cfg.wdata[CLKSEL_W-1:0];
				REG_COMPARE_A:       compare_a_q       <= cfg.wdata;
				REG_COMPARE_B:       compare_b_q       <= cfg.wdata;
				REG_TOP_VALUE:       top_value_q       <= cfg.wdata;
				REG_CAPTURE_RISING:  capture_rising_q  <= cfg.wdata[0];
				REG_NOISE_FILTER_ON: noise_filter_on_q <= cfg.wdata[0];
				REG_EVENT_ENABLES:   event_enables_q   <= cfg.wdata[ENABLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Timer state. A counter write replaces the count only: the prescaler holds and
	// the pin is not sampled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q    <= '0;
			timer_q       <= '0;
			capture_q     <= '0;
			pin_history_q <= '0;
			filtered_q    <= 1'b0;
		end else if (accept) begin
			if (is_tick) begin
				prescale_q    <= prescale_next;
				timer_q       <= timer_next;
				capture_q     <= capture_next;
				pin_history_q <= history_next;
				filtered_q    <= level_next;
			end else begin
				timer_q <= tick.write_value;
			end
		end
	end

	// Result register. The events are masked by the enables and are always clear
	// for a counter write. The payload clears on reset so that it matches the
	// cleared capture latch before the first result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q   <= 1'b0;
			res_count_q   <= '0;
			res_capture_q <= '0;
			res_ev_a_q    <= 1'b0;
			res_ev_b_q    <= 1'b0;
			res_ev_cap_q  <= 1'b0;
		end else begin
			res_valid_q <= accept || (res_valid_q && !result.ready);
			if (accept) begin
				res_count_q   <= is_tick ? timer_next : tick.write_value;
				res_capture_q <= is_tick ? capture_next : capture_q;
				res_ev_a_q    <= is_tick && timer_clock && match_a
					&& event_enables_q[EN_COMPARE_A];
				res_ev_b_q    <= is_tick && timer_clock && match_b
					&& event_enables_q[EN_COMPARE_B];
				res_ev_cap_q  <= is_tick && capture_hit && event_enables_q[EN_CAPTURE];
			end
		end
	end

	assign result.valid           = res_valid_q;
	assign result.count_now       = res_count_q;
	assign result.captured_count  = res_capture_q;
	assign result.compare_a_event = res_ev_a_q;
	assign result.compare_b_event = res_ev_b_q;
	assign result.capture_event   = res_ev_cap_q;

endmodule

`default_nettype wire

### hdl/tcc_checker.sv
`default_nettype none

module tcc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        tick_valid,
	input wire logic        tick_ready,
	input wire logic        tick_operation,
	input wire logic [15:0] tick_write_value,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [15:0] res_count_now,
	input wire logic [15:0] res_captured_count,
	input wire logic        res_compare_a_event,
	input wire logic        res_compare_b_event,
	input wire logic        res_capture_event
);
	import tcc_pkg::*;

	logic stalled;
	logic write_accepted;

	assign stalled        = res_valid && !res_ready;
	assign write_accepted = tick_valid && tick_ready && (tick_operation == OP_WRITE);

	// A pending result is held until it is taken.
	a_res_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stalled |=> res_valid)
		else $error("result request dropped while stalled");

	a_res_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stalled |=> ($stable(res_count_now) && $stable(res_captured_count)))
		else $error("result payload changed while stalled");

	// The input only stalls behind a result that is waiting.
	a_ready_only_stalls_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> stalled)
		else $error("input stalled without a waiting result");

	// A counter write shows the written value in its result and raises no event.
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		write_accepted |=> (res_valid && res_count_now == $past(tick_write_value)
			&& !res_compare_a_event && !res_compare_b_event && !res_capture_event))
		else $error("counter write result wrong");

	// A counter write leaves the capture latch untouched.
	a_write_keeps_capture: assert property (@(posedge clk) disable iff (!arst_n)
		write_accepted |=> (res_captured_count == $past(res_captured_count)))
		else $error("counter write disturbed the capture latch");

endmodule

bind timer_counter_16bit_capture_compare tcc_checker u_tcc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.tick_valid          (tick.valid),
	.tick_ready          (tick.ready),
	.tick_operation      (tick.operation),
	.tick_write_value    (tick.write_value),
	.res_valid           (result.valid),
	.res_ready           (result.ready),
	.res_count_now       (result.count_now),
	.res_captured_count  (result.captured_count),
	.res_compare_a_event (result.compare_a_event),
	.res_compare_b_event (result.compare_b_event),
	.res_capture_event   (result.capture_event)
);

`default_nettype wire

### tb/tb_timer_counter_16bit_capture_compare.sv
`timescale 1ns / 1ps

module tb_timer_counter_16bit_capture_compare;
	import tcc_pkg::*;

	// The block is built with the default filter depth of four samples.
	localparam int FILTER_SAMPLES = 4;

	// Reserved register codes: the spare mode must behave as the free-running wrap and the
	// spare clock selects as a stopped clock.
	localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;
	localparam logic [CLKSEL_W-1:0] CS_UNUSED   = 3'd6;

	// The receiver holds off once during the run, long enough for the single result
	// register to fill and the request side to stall.
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic [COUNT_W-1:0] count_now;
		logic [COUNT_W-1:0] captured_count;
		logic               compare_a_event;
		logic               compare_b_event;
		logic               capture_event;
	} timer_result_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [CLKSEL_W-1:0] clksel;
		logic [COUNT_W-1:0]  cmp_a;
		logic [COUNT_W-1:0]  cmp_b;
		logic [COUNT_W-1:0]  top;
		logic                rising;
		logic                filter;
		logic [ENABLE_W-1:0] enables;
	} timer_settings_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcc_cfg_if    cfg_bus ();
	tcc_tick_if   tick_bus ();
	tcc_result_if result_bus ();

	timer_counter_16bit_capture_compare #(
		.FILTER_SAMPLES(FILTER_SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.tick(tick_bus),
		.result(result_bus)
	);

	// Free-running 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Our own copy of the configuration registers, updated as each write is accepted.
	logic [MODE_W-1:0]   mode_reg    = '0;
	logic [CLKSEL_W-1:0] clksel_reg  = '0;
	logic [COUNT_W-1:0]  cmp_a_reg   = '0;
	logic [COUNT_W-1:0]  cmp_b_reg   = '0;
	logic [COUNT_W-1:0]  top_reg     = '0;
	logic                rising_reg  = 1'b0;
	logic                filter_reg  = 1'b0;
	logic [ENABLE_W-1:0] enables_reg = '0;

	// Our own copy of the timer state; everything clears to zero on reset.
	logic [PRESCALE_W-1:0]     prescale_count = '0;
	logic [COUNT_W-1:0]        timer_count    = '0;
	logic [COUNT_W-1:0]        capture_latch  = '0;
	logic [FILTER_SAMPLES-1:0] pin_history    = '0;
	logic                      filtered_level = 1'b0;

	// Results still owed by the block, oldest first.
	timer_result_t timer_results_due[$];

	int error_count = 0;
	int report_count = 0;

	// Shared controls between the request sequence and the receiver.
	bit stalls_enabled = 1'b1;
	bit hold_off_pending = 1'b0;

	// State of the capture pin generator used by the random traffic.
	logic pin_level = 1'b0;
	int   pin_run_left = 0;

	// Works out what the block should return for one request, and moves our copy of the
	// timer state on by the same step.
	function automatic timer_result_t advance_timer(logic op, logic pin,
			logic [COUNT_W-1:0] new_count);
		timer_result_t r;
		logic [COUNT_W-1:0] held;
		logic prev_level;
		logic fires;
		logic hit_a;
		logic hit_b;
		logic hit_capture;
		hit_a = 1'b0;
		hit_b = 1'b0;
		hit_capture = 1'b0;
		if (op == OP_WRITE) begin
			// A counter write leaves the prescaler and the pin history alone.
			timer_count = new_count;
		end else begin
			held = timer_count;
			prev_level = filtered_level;

			// The history shifts on every tick, whether or not the filter is in use.
			pin_history = {pin_history[FILTER_SAMPLES-2:0], pin};
			if (!filter_reg) begin
				filtered_level = pin;
			end else if (&pin_history) begin
				filtered_level = 1'b1;
			end else if (pin_history == '0) begin
				filtered_level = 1'b0;
			end

			// The edge detector keeps tracking in top-register mode, but nothing is latched.
			if (filtered_level != prev_level && filtered_level == rising_reg &&
					mode_reg != MODE_CLEAR_TOP) begin
				capture_latch = held;
				hit_capture = 1'b1;
			end

			prescale_count = prescale_count + PRESCALE_W'(1);
			case (clksel_reg)
				CS_DIV1:    fires = 1'b1;
				CS_DIV8:    fires = (prescale_count[2:0] == '0);
				CS_DIV64:   fires = (prescale_count[5:0] == '0);
				CS_DIV256:  fires = (prescale_count[7:0] == '0);
				CS_DIV1024: fires = (prescale_count == '0);
				default:    fires = 1'b0;
			endcase

			// Compares only match on a timer clock, against the count held at its start.
			if (fires) begin
				hit_a = (held == cmp_a_reg);
				hit_b = (held == cmp_b_reg);
				if (mode_reg == MODE_CLEAR_A && held == cmp_a_reg) begin
					timer_count = '0;
				end else if (mode_reg == MODE_CLEAR_TOP && held == top_reg) begin
					timer_count = '0;
				end else begin
					timer_count = held + COUNT_W'(1);
				end
			end
		end
		r.count_now       = timer_count;
		r.captured_count  = capture_latch;
		r.compare_a_event = hit_a & enables_reg[EN_COMPARE_A];
		r.compare_b_event = hit_b & enables_reg[EN_COMPARE_B];
		r.capture_event   = hit_capture & enables_reg[EN_CAPTURE];
		return r;
	endfunction

	// Follows every accepted register write and every accepted request. Inputs are driven
	// with nonblocking assignments, so the values read here are those of the edge itself.
	always @(posedge clk) begin : timer_tracker
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					REG_TIMER_MODE:      mode_reg    = cfg_bus.wdata[MODE_W-1:0];
					REG_CLOCK_SELECT:    clksel_reg  = cfg_bus.wdata[CLKSEL_W-1:0];
					REG_COMPARE_A:       cmp_a_reg   = cfg_bus.wdata;
					REG_COMPARE_B:       cmp_b_reg   = cfg_bus.wdata;
					REG_TOP_VALUE:       top_reg     = cfg_bus.wdata;
					REG_CAPTURE_RISING:  rising_reg  = cfg_bus.wdata[0];
					REG_NOISE_FILTER_ON: filter_reg  = cfg_bus.wdata[0];
					REG_EVENT_ENABLES:   enables_reg = cfg_bus.wdata[ENABLE_W-1:0];
					default: ;
				endcase
			end
			if (tick_bus.valid && tick_bus.ready) begin
				timer_results_due.push_back(advance_timer(tick_bus.operation,
					tick_bus.capture_pin, tick_bus.write_value));
			end
		end
	end

	// Compares every result taken from the block against the oldest one still owed.
	always @(posedge clk) begin : result_checker
		timer_result_t want;
		timer_result_t got;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got.count_now       = result_bus.count_now;
			got.captured_count  = result_bus.captured_count;
			got.compare_a_event = result_bus.compare_a_event;
			got.compare_b_event = result_bus.compare_b_event;
			got.capture_event   = result_bus.capture_event;
			if (timer_results_due.size() == 0) begin
				error_count++;
				if (report_count < MAX_REPORTS) begin
					report_count++;
					$display("Unexpected result at %0t: count %h captured %h events %b%b%b",
						$time, got.count_now, got.captured_count, got.compare_a_event,
						got.compare_b_event, got.capture_event);
				end
			end else begin
				want = timer_results_due.pop_front();
				if (got.count_now !== want.count_now ||
						got.captured_count !== want.captured_count ||
						got.compare_a_event !== want.compare_a_event ||
						got.compare_b_event !== want.compare_b_event ||
						got.capture_event !== want.capture_event) begin
					error_count++;
					if (report_count < MAX_REPORTS) begin
						report_count++;
						$display({"Mismatch at %0t (expected/actual): count %h/%h ",
							"captured %h/%h compare A %b/%b compare B %b/%b capture %b/%b"},
							$time, want.count_now, got.count_now, want.captured_count,
							got.captured_count, want.compare_a_event, got.compare_a_event,
							want.compare_b_event, got.compare_b_event, want.capture_event,
							got.capture_event);
					end
				end
			end
		end
	end

	// The receiver. It normally takes results at once, stalls now and then in short bursts,
	// and once in the run holds off for a long stretch, counting the cycles itself.
	initial begin : result_receiver
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				result_bus.ready <= 1'b0;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++)
					@(posedge clk);
				result_bus.ready <= 1'b1;
				hold_off_pending = 1'b0;
			end else if (stalls_enabled && $urandom_range(0, 9) == 0) begin
				result_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				result_bus.ready <= 1'b1;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Offers one request and returns at the edge where it is accepted. Valid is left high, so
	// a following request goes out back to back; an idle burst lowers it first.
	task automatic send_request(logic op, logic pin, logic [COUNT_W-1:0] new_count);
		if (stalls_enabled && $urandom_range(0, 7) == 0) begin
			tick_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		tick_bus.valid       <= 1'b1;
		tick_bus.operation   <= op;
		tick_bus.capture_pin <= pin;
		tick_bus.write_value <= new_count;
		do @(posedge clk); while (!tick_bus.ready);
	endtask

	// Stops offering requests until every owed result has come back.
	task automatic wait_for_results;
		tick_bus.valid <= 1'b0;
		do @(posedge clk); while (timer_results_due.size() != 0);
		@(posedge clk);
	endtask

	// Writes one register; valid stays high so that writes can follow each other.
	task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.wdata <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// Registers are only ever written with the block idle, so drain it first.
	task automatic apply_settings(timer_settings_t s);
		wait_for_results();
		write_register(REG_TIMER_MODE, COUNT_W'(s.mode));
		write_register(REG_CLOCK_SELECT, COUNT_W'(s.clksel));
		write_register(REG_COMPARE_A, s.cmp_a);
		write_register(REG_COMPARE_B, s.cmp_b);
		write_register(REG_TOP_VALUE, s.top);
		write_register(REG_CAPTURE_RISING, COUNT_W'(s.rising));
		write_register(REG_NOISE_FILTER_ON, COUNT_W'(s.filter));
		write_register(REG_EVENT_ENABLES, COUNT_W'(s.enables));
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic timer_settings_t make_settings(logic [MODE_W-1:0] mode,
			logic [CLKSEL_W-1:0] clksel, logic [COUNT_W-1:0] cmp_a, logic [COUNT_W-1:0] cmp_b,
			logic [COUNT_W-1:0] top, logic rising, logic filter, logic [ENABLE_W-1:0] enables);
		timer_settings_t s;
		s.mode    = mode;
		s.clksel  = clksel;
		s.cmp_a   = cmp_a;
		s.cmp_b   = cmp_b;
		s.top     = top;
		s.rising  = rising;
		s.filter  = filter;
		s.enables = enables;
		return s;
	endfunction

	// Register values lean towards the extremes and towards small numbers, so that the
	// counter reaches the compare and top values often.
	function automatic logic [COUNT_W-1:0] pick_value();
		logic [COUNT_W-1:0] v;
		case ($urandom_range(0, 7))
			0:       v = '0;
			1:       v = '1;
			2, 3, 4: v = COUNT_W'($urandom_range(0, 40));
			default: v = COUNT_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic timer_settings_t random_settings();
		timer_settings_t s;
		s.mode = MODE_W'($urandom_range(0, 3));
		// Fast clocks most of the time; the slow dividers and the stopped codes still turn up.
		case ($urandom_range(0, 9))
			0, 1, 2, 3: s.clksel = CS_DIV1;
			4, 5:       s.clksel = CS_DIV8;
			default:    s.clksel = CLKSEL_W'($urandom_range(0, 7));
		endcase
		s.cmp_a   = pick_value();
		s.cmp_b   = pick_value();
		s.top     = pick_value();
		s.rising  = 1'($urandom_range(0, 1));
		s.filter  = 1'($urandom_range(0, 1));
		s.enables = ENABLE_W'($urandom_range(0, 7));
		return s;
	endfunction

	// The pin mostly holds its level for long enough to get through the filter, with short
	// glitches in between.
	function automatic logic next_pin_level();
		if (pin_run_left == 0) begin
			pin_level = ~pin_level;
			pin_run_left = ($urandom_range(0, 9) < 7) ? $urandom_range(4, 12)
				: $urandom_range(1, 3);
		end
		pin_run_left--;
		return pin_level;
	endfunction

	// Mostly ticks; now and then a counter write, usually to just below one of the values
	// the counter is compared with, so that matches and clears come round soon.
	task automatic send_random_request(timer_settings_t s);
		logic [COUNT_W-1:0] target;
		logic [COUNT_W-1:0] back_off;
		logic junk_pin;
		junk_pin = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 15) == 0) begin
			back_off = COUNT_W'($urandom_range(0, 6));
			case ($urandom_range(0, 3))
				0:       target = s.cmp_a - back_off;
				1:       target = s.cmp_b - back_off;
				2:       target = s.top - back_off;
				default: target = COUNT_W'($urandom);
			endcase
			send_request(OP_WRITE, junk_pin, target);
		end else begin
			target = COUNT_W'($urandom);
			send_request(OP_TICK, next_pin_level(), target);
		end
	endtask

	// Stopped clock, both compares, wrap at the top of the range, a rising capture, and
	// counter writes near both ends of the range.
	task automatic test_wrap_and_compare;
		apply_settings(make_settings(MODE_WRAP, CS_STOPPED, 16'hFFFE, 16'hFFFF, 16'hFFFF,
			1'b1, 1'b0, '1));
		send_request(OP_WRITE, 1'b1, 16'hFFFE);
		// With the clock stopped the count sits on compare A but no event may appear.
		send_request(OP_TICK, 1'b0, 16'h0000);
		apply_settings(make_settings(MODE_WRAP, CS_DIV1, 16'hFFFE, 16'hFFFF, 16'hFFFF,
			1'b1, 1'b0, '1));
		send_request(OP_TICK, 1'b0, 16'hFFFF);
		send_request(OP_TICK, 1'b0, 16'h0000);
		send_request(OP_TICK, 1'b1, 16'hFFFF);
		send_request(OP_WRITE, 1'b0, 16'h0000);
	endtask

	// Clear at compare A, a count written beyond compare A, clear at the top register with
	// capture disabled, and the spare mode code behaving as a plain wrap.
	task automatic test_clear_modes;
		apply_settings(make_settings(MODE_CLEAR_A, CS_DIV1, 16'd2, 16'd1, 16'd0,
			1'b0, 1'b0, 3'b011));
		send_request(OP_WRITE, 1'b1, 16'd1);
		send_request(OP_TICK, 1'b1, 16'd0);
		// Falling edge: latched, though the capture event is masked off.
		send_request(OP_TICK, 1'b0, 16'd0);
		send_request(OP_WRITE, 1'b0, 16'hFFFF);
		send_request(OP_TICK, 1'b0, 16'd0);
		apply_settings(make_settings(MODE_CLEAR_TOP, CS_DIV1, 16'd0, 16'd0, 16'd1,
			1'b1, 1'b0, '1));
		send_request(OP_TICK, 1'b1, 16'd0);
		send_request(OP_TICK, 1'b0, 16'd0);
		apply_settings(make_settings(MODE_UNUSED, CS_DIV1, 16'd5, 16'd0, 16'd5,
			1'b0, 1'b0, '1));
		send_request(OP_WRITE, 1'b0, 16'd5);
		send_request(OP_TICK, 1'b0, 16'd0);
	endtask

	// Divide by eight with the noise filter on: a glitch must not get through, and four
	// equal samples must. Then a spare clock code, which must leave the count alone.
	task automatic test_prescaler_and_filter;
		logic pins [10] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
		apply_settings(make_settings(MODE_WRAP, CS_DIV8, 16'd0, 16'd0, 16'd0,
			1'b0, 1'b1, '1));
		foreach (pins[i])
			send_request(OP_TICK, pins[i], 16'd0);
		apply_settings(make_settings(MODE_WRAP, CS_UNUSED, 16'd0, 16'd0, 16'd0,
			1'b0, 1'b0, '1));
		send_request(OP_TICK, 1'b1, 16'd0);
	endtask

	// The receiver holds off for a long stretch while requests keep being offered, so the
	// result register fills and the request side has to stall.
	task automatic test_backpressure;
		timer_settings_t s;
		s = random_settings();
		s.clksel = CS_DIV1;
		apply_settings(s);
		hold_off_pending = 1'b1;
		for (int i = 0; i < 40; i++)
			send_random_request(s);
		while (hold_off_pending)
			@(posedge clk);
		wait_for_results();
	endtask

	task automatic test_random_traffic(int phases, int requests_per_phase);
		timer_settings_t s;
		for (int p = 0; p < phases; p++) begin
			s = random_settings();
			apply_settings(s);
			for (int i = 0; i < requests_per_phase; i++)
				send_random_request(s);
		end
	endtask

	initial begin : test_sequence
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_TIMER_MODE;
		cfg_bus.wdata = '0;
		tick_bus.valid = 1'b0;
		tick_bus.operation = OP_TICK;
		tick_bus.capture_pin = 1'b0;
		tick_bus.write_value = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wrap_and_compare();
		test_clear_modes();
		test_prescaler_and_filter();
		test_backpressure();
		test_random_traffic(12, 110);

		// The last stretch runs flat out on both sides.
		stalls_enabled = 1'b0;
		test_random_traffic(1, 150);

		wait_for_results();
		repeat (4) @(posedge clk);
		error_count += timer_results_due.size();
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Backstop in case the block stops answering; far beyond any correct run.
	initial begin : watchdog
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
hdl/tcc_pkg.sv
hdl/tcc_cfg_if.sv
hdl/tcc_tick_if.sv
hdl/tcc_result_if.sv
hdl/timer_counter_16bit_capture_compare.sv
hdl/tcc_checker.sv
tb/tb_timer_counter_16bit_capture_compare.sv
